/* sv/lfu_cache_controller_defines.svh */
// Assertion macros for the LFU cache controller.
`ifndef LFU_CACHE_CONTROLLER_DEFINES_SVH
`define LFU_CACHE_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define LFU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfu cache controller: assertion failed");
`define LFU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfu cache controller: assertion failed");
`else
`define LFU_ASSERT_IMP(lbl, ante, cons)
`define LFU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* sv/lfu_pkg.sv */
// Shared constants, codes and types of the LFU cache controller.
package lfu_pkg;

	localparam int DEF_ENTRIES    = 16;
	localparam int DEF_KEY_BITS   = 32;
	localparam int DEF_VALUE_BITS = 32;
	localparam int DEF_COUNT_BITS = 16;

	localparam int DATA_BITS = 32;
	localparam int ADDR_BITS = 3;
	localparam int CAP_BITS  = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic vld;
	} scan_ctl_t;

	typedef struct packed {
		logic found;
		logic have;
		logic free_ok;
	} scan_stat_t;

endpackage

/* sv/lfu_ram.sv */
// Generic single-port synchronous RAM with registered read.
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

/* sv/lfu_rank.sv */
// Recency rank lanes: one rank per entry, aged in parallel on a touch.
module lfu_rank #(
	parameter int ENTRIES = lfu_pkg::DEF_ENTRIES,
	parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	parameter int RANK_W  = IDX_W,
	parameter int FILL_W  = $clog2(ENTRIES + 1)
) (
	input  logic              clk,
	input  logic              touch,
	input  logic [IDX_W-1:0]  touch_idx,
	input  logic [FILL_W-1:0] old_rank,
	input  logic [ENTRIES-1:0] valid,
	input  logic [IDX_W-1:0]  rd_idx,
	output logic [RANK_W-1:0] rd_rank
);

	logic [RANK_W-1:0] rank_q [ENTRIES];

	for (genvar j = 0; j < ENTRIES; j++) begin : g_lane
		always_ff @(posedge clk) begin
			if (touch) begin
				if (touch_idx == IDX_W'(j)) begin
					rank_q[j] <= '0;
				end else if (valid[j] && (FILL_W'(rank_q[j]) < old_rank)) begin
					rank_q[j] <= rank_q[j] + RANK_W'(1);
				end
			end
		end
	end

	assign rd_rank = rank_q[rd_idx];

endmodule

/* sv/lfu_scan.sv */
// Scan tracker: key match, LFU victim and first free slot over one pass.
module lfu_scan #(
	parameter int KEY_BITS   = lfu_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS = lfu_pkg::DEF_VALUE_BITS,
	parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS,
	parameter int IDX_W      = 4,
	parameter int RANK_W     = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lfu_pkg::scan_ctl_t      ctl,
	input  logic [IDX_W-1:0]        idx,
	input  logic                    entry_valid,
	input  logic [KEY_BITS-1:0]     entry_key,
	input  logic [VALUE_BITS-1:0]   entry_value,
	input  logic [COUNT_BITS-1:0]   entry_count,
	input  logic [RANK_W-1:0]       entry_rank,
	input  logic [KEY_BITS-1:0]     look_key,
	output lfu_pkg::scan_stat_t     stat,
	output logic [IDX_W-1:0]        found_idx,
	output logic [VALUE_BITS-1:0]   found_value,
	output logic [COUNT_BITS-1:0]   found_count,
	output logic [RANK_W-1:0]       found_rank,
	output logic [IDX_W-1:0]        vic_idx,
	output logic [KEY_BITS-1:0]     vic_key,
	output logic [RANK_W-1:0]       vic_rank,
	output logic [IDX_W-1:0]        free_idx
);

	lfu_pkg::scan_stat_t stat_q;
	logic [IDX_W-1:0]      found_idx_q, vic_idx_q, free_idx_q;
	logic [VALUE_BITS-1:0] found_value_q;
	logic [COUNT_BITS-1:0] found_count_q, vic_count_q;
	logic [RANK_W-1:0]     found_rank_q, vic_rank_q;
	logic [KEY_BITS-1:0]   vic_key_q;
	logic match, better, free;

	always_comb begin
		match  = ctl.vld && entry_valid && (entry_key == look_key) && !stat_q.found;
		// lower count wins, equal count goes to the older entry
		better = ctl.vld && entry_valid && (!stat_q.have || (entry_count < vic_count_q) ||
			((entry_count == vic_count_q) && (entry_rank > vic_rank_q)));
		free   = ctl.vld && !entry_valid && !stat_q.free_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
		end else if (ctl.clear) begin
			stat_q <= '0;
		end else begin
			if (match) stat_q.found <= 1'b1;
			if (better) stat_q.have <= 1'b1;
			if (free) stat_q.free_ok <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (match) begin
			found_idx_q   <= idx;
			found_value_q <= entry_value;
			found_count_q <= entry_count;
			found_rank_q  <= entry_rank;
		end
		if (better) begin
			vic_idx_q   <= idx;
			vic_key_q   <= entry_key;
			vic_count_q <= entry_count;
			vic_rank_q  <= entry_rank;
		end
		if (free) begin
			free_idx_q <= idx;
		end
	end

	assign stat        = stat_q;
	assign found_idx   = found_idx_q;
	assign found_value = found_value_q;
	assign found_count = found_count_q;
	assign found_rank  = found_rank_q;
	assign vic_idx     = vic_idx_q;
	assign vic_key     = vic_key_q;
	assign vic_rank    = vic_rank_q;
	assign free_idx    = free_idx_q;

endmodule

/* sv/lfu_cache_controller.sv */
// Top level of the LFU cache controller: control FSM, config register, datapath.
//
// Fully associative key/value cache, least frequently used replacement,
// least recently touched entry first among equal use counts.
// Command channel: a word (func, lookup_key, write_value) is taken at a
// rising edge with start high and busy low. func 0 is a get, 1 a put.
// Result channel: done is high for one cycle with hit, read_value, evicted
// and evicted_key; the receiver cannot stall, so the word must be taken then.
// Each command scans all ENTRIES slots of the entry RAM, one read per cycle,
// then passes through a drain state for the last read and a commit state
// for the write-back. busy is high in the scan and drain states; a new
// command can be taken in the write-back cycle, and done is registered
// from the commit state.
// APB register 0 (capacity_in_use) holds the entry limit; write it only
// while idle. Reset clears all valid bits and the fill count and sets the
// capacity to 16; no clearing pass over the RAM is needed.
`include "lfu_cache_controller_defines.svh"
module lfu_cache_controller #(
	parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
	parameter int KEY_BITS   = lfu_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS = lfu_pkg::DEF_VALUE_BITS,
	parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lfu_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [lfu_pkg::DATA_BITS-1:0]    pwdata,
	output logic [lfu_pkg::DATA_BITS-1:0]    prdata,
	output logic                             pready,
	input  logic                             start,
	output logic                             busy,
	input  logic                             func,
	input  logic [KEY_BITS-1:0]              lookup_key,
	input  logic signed [VALUE_BITS-1:0]     write_value,
	output logic                             done,
	output logic                             hit,
	output logic signed [VALUE_BITS-1:0]     read_value,
	output logic                             evicted,
	output logic [KEY_BITS-1:0]              evicted_key
);

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int FILL_W = $clog2(ENTRIES + 1);
	localparam int CW     = (FILL_W > lfu_pkg::CAP_BITS) ? FILL_W : lfu_pkg::CAP_BITS;
	localparam int WORD_W = KEY_BITS + VALUE_BITS + COUNT_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	lfu_pkg::state_t state_q, state_nxt;
	logic [lfu_pkg::CAP_BITS-1:0] capacity_q;
	logic [FILL_W-1:0]  fill_q;
	logic [ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]   rd_idx_q, idx_s1;
	logic               vld_s1;

	logic                  func_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] wval_q;

	logic                  done_q, hit_q, ev_q;
	logic [VALUE_BITS-1:0] rval_q;
	logic [KEY_BITS-1:0]   evkey_q;

	logic accept, cfg_wr, commit;
	logic ram_en, ram_we;
	logic [IDX_W-1:0]  ram_addr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	lfu_pkg::scan_ctl_t  scan_ctl;
	lfu_pkg::scan_stat_t stat;
	logic [IDX_W-1:0]      found_idx, vic_idx, free_idx;
	logic [VALUE_BITS-1:0] found_value;
	logic [COUNT_BITS-1:0] found_count;
	logic [RANK_W-1:0]     found_rank, vic_rank, rd_rank;
	logic [KEY_BITS-1:0]   vic_key;

	logic [CW-1:0] cap_ext, cap_eff;
	logic do_upd, do_evict, do_fill, touch;
	logic [IDX_W-1:0]      wr_idx;
	logic [VALUE_BITS-1:0] wr_value;
	logic [COUNT_BITS-1:0] wr_count;
	logic [FILL_W-1:0]     old_rank;

	// ---- config port ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[2] == lfu_pkg::REG_CAPACITY);
	assign prdata = (paddr[2] == lfu_pkg::REG_CAPACITY) ?
		lfu_pkg::DATA_BITS'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lfu_pkg::CAP_RESET;
		end else if (cfg_wr) begin
			capacity_q <= pwdata[lfu_pkg::CAP_BITS-1:0];
		end
	end

	// ---- FSM ----
	assign accept = start && !busy;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lfu_pkg::ST_IDLE:   if (accept) state_nxt = lfu_pkg::ST_SCAN;
			lfu_pkg::ST_SCAN:   if (rd_idx_q == LAST_IDX) state_nxt = lfu_pkg::ST_DRAIN;
			lfu_pkg::ST_DRAIN:  state_nxt = lfu_pkg::ST_COMMIT;
			lfu_pkg::ST_COMMIT: state_nxt = accept ? lfu_pkg::ST_SCAN : lfu_pkg::ST_IDLE;
			default:            state_nxt = lfu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy     = 1'b0;
		commit   = 1'b0;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = rd_idx_q;
		case (state_q)
			lfu_pkg::ST_SCAN: begin
				busy   = 1'b1;
				ram_en = 1'b1;
			end
			lfu_pkg::ST_DRAIN: begin
				busy = 1'b1;
			end
			lfu_pkg::ST_COMMIT: begin
				commit   = 1'b1;
				ram_en   = touch;
				ram_we   = touch;
				ram_addr = wr_idx;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lfu_pkg::ST_IDLE;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			fill_q   <= '0;
			valid_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			vld_s1  <= (state_q == lfu_pkg::ST_SCAN);
			done_q  <= commit;
			if (accept) begin
				rd_idx_q <= '0;
			end else if (state_q == lfu_pkg::ST_SCAN) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			if (commit && do_fill) begin
				valid_q[wr_idx] <= 1'b1;
				fill_q          <= fill_q + FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (accept) begin
			func_q <= func;
			key_q  <= lookup_key;
			wval_q <= write_value;
		end
		if (commit) begin
			hit_q   <= stat.found;
			rval_q  <= (stat.found && (func_q == lfu_pkg::FUNC_GET)) ? found_value : '1;
			ev_q    <= do_evict;
			evkey_q <= do_evict ? vic_key : '0;
		end
	end

	// ---- entry store and scan ----
	assign ram_wdata = {key_q, wr_value, wr_count};

	lfu_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	lfu_rank #(
		.ENTRIES(ENTRIES),
		.IDX_W  (IDX_W),
		.RANK_W (RANK_W),
		.FILL_W (FILL_W)
	) u_rank (
		.clk      (clk),
		.touch    (commit && touch),
		.touch_idx(wr_idx),
		.old_rank (old_rank),
		.valid    (valid_q),
		.rd_idx   (idx_s1),
		.rd_rank  (rd_rank)
	);

	assign scan_ctl.clear = accept;
	assign scan_ctl.vld   = vld_s1;

	lfu_scan #(
		.KEY_BITS  (KEY_BITS),
		.VALUE_BITS(VALUE_BITS),
		.COUNT_BITS(COUNT_BITS),
		.IDX_W     (IDX_W),
		.RANK_W    (RANK_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.idx        (idx_s1),
		.entry_valid(valid_q[idx_s1]),
		.entry_key  (ram_rdata[WORD_W-1 -: KEY_BITS]),
		.entry_value(ram_rdata[COUNT_BITS +: VALUE_BITS]),
		.entry_count(ram_rdata[COUNT_BITS-1:0]),
		.entry_rank (rd_rank),
		.look_key   (key_q),
		.stat       (stat),
		.found_idx  (found_idx),
		.found_value(found_value),
		.found_count(found_count),
		.found_rank (found_rank),
		.vic_idx    (vic_idx),
		.vic_key    (vic_key),
		.vic_rank   (vic_rank),
		.free_idx   (free_idx)
	);

	// ---- write-back decision ----
	always_comb begin
		cap_ext = CW'(capacity_q);
		cap_eff = cap_ext;
		if (cap_ext == '0) begin
			cap_eff = CW'(1);
		end else if (cap_ext > CW'(ENTRIES)) begin
			cap_eff = CW'(ENTRIES);
		end
	end

	always_comb begin
		do_upd   = 1'b0;
		do_evict = 1'b0;
		do_fill  = 1'b0;
		wr_idx   = found_idx;
		wr_value = wval_q;
		wr_count = COUNT_BITS'(1);
		old_rank = FILL_W'(found_rank);
		if (stat.found) begin
			do_upd   = 1'b1;
			wr_value = (func_q == lfu_pkg::FUNC_PUT) ? wval_q : found_value;
			// saturate instead of wrapping
			wr_count = (found_count == '1) ? found_count : found_count + COUNT_BITS'(1);
		end else if (func_q == lfu_pkg::FUNC_PUT) begin
			if ((CW'(fill_q) >= cap_eff) && stat.have) begin
				do_evict = 1'b1;
				wr_idx   = vic_idx;
				old_rank = FILL_W'(vic_rank);
			end else if (stat.free_ok) begin
				do_fill  = 1'b1;
				wr_idx   = free_idx;
				old_rank = fill_q;
			end
		end
		touch = do_upd || do_evict || do_fill;
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign read_value  = rval_q;
	assign evicted     = ev_q;
	assign evicted_key = evkey_q;

	`LFU_ASSERT_NXT(a_commit_done, state_q == lfu_pkg::ST_COMMIT, done)
	`LFU_ASSERT_IMP(a_evict_on_miss, done && evicted, !hit)
	`LFU_ASSERT_IMP(a_fill_tracks_valid, 1'b1, $countones(valid_q) == int'(fill_q))

endmodule
